// File: sv/pcd_pkg.sv
// Shared constants and types for the prefix code table decoder.
package pcd_pkg;

    localparam int SYM_W            = 8;
    localparam int LEN_W            = 6;
    localparam int CODE_W           = 32;
    localparam int BITS_PER_BYTE    = 8;
    localparam int BIT_CNT_W        = $clog2(BITS_PER_BYTE);
    localparam int DEF_NUM_SYMBOLS  = 256;
    localparam int DEF_MAX_CODE_LEN = 32;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic             push;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic             bad;
    } rq_req_t;

    typedef struct packed {
        logic ready;
        logic held;
    } rq_stat_t;

endpackage

// File: sv/prefix_code_table_decoder.sv
// Top level of the prefix code table decoder: bit sequencer, table scan and result path.
// A load transaction (action 0) writes one table entry. A decode transaction
// (action 1) shifts the byte in one bit at a time, most significant first; after each bit the
// table memory is read one entry per cycle from symbol 0 upward through its single read port,
// and the scan stops at the first entry whose length and code equal the pending bits. Each bit
// is shifted in and then scanned; a match, or no match once MAX_CODE_LEN bits are pending (an
// error), issues a result, which may wait on the result path. The scan ends early when codes
// match on low symbols. Results leave through an output register; a result is released once the
// next result of the same byte or the end of the byte is known, so that last_of_run is exact.
// Table entries come out of reset unused through per-entry valid bits, with no clearing pass.
module prefix_code_table_decoder
    import pcd_pkg::*;
#(
    parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [SYM_W-1:0]  entry_symbol,
    input  logic [LEN_W-1:0]  entry_length,
    input  logic [CODE_W-1:0] entry_code,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SYM_W-1:0]  out_symbol,
    output logic              bad_code,
    output logic              last_of_run
);

    localparam int AW        = $clog2(NUM_SYMBOLS);
    localparam int CNT_W     = $clog2(MAX_CODE_LEN + 1);
    localparam int SYM_CMP_W = SYM_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_SCAN,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    state_t                   state_reg, state_next;
    logic [BITS_PER_BYTE-1:0] byte_reg, byte_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [MAX_CODE_LEN-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [AW-1:0]            scan_idx_reg, scan_idx_next;
    logic                     issue_done_reg, issue_done_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [SYM_W-1:0]         res_sym_reg, res_sym_next;
    logic                     res_bad_reg, res_bad_next;

    logic                     tbl_wr_en;
    logic                     sym_ok;
    logic [LEN_W-1:0]         rd_len;
    logic [CODE_W-1:0]        rd_code;
    logic                     hit;
    logic                     last_idx;
    logic                     last_bit;
    logic                     at_limit;
    rq_req_t                  rq_req;
    rq_stat_t                 rq_st;

    assign sym_ok    = {1'b0, entry_symbol} < SYM_CMP_W'(NUM_SYMBOLS);
    assign in_ready  = (state_reg == ST_IDLE);
    assign tbl_wr_en = in_valid && in_ready && (action == ACT_LOAD) && sym_ok;

    pcd_table #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (entry_symbol[AW-1:0]),
        .wr_len  (entry_length),
        .wr_code (entry_code),
        .rd_addr (scan_idx_reg),
        .rd_len  (rd_len),
        .rd_code (rd_code)
    );

    pcd_result_q u_result_q (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (rq_req),
        .st          (rq_st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_symbol  (out_symbol),
        .bad_code    (bad_code),
        .last_of_run (last_of_run)
    );

    assign hit = cmp_vld_reg && (rd_len != '0) && (rd_len == LEN_W'(count_reg))
                 && (rd_code == CODE_W'(pending_reg));
    assign last_idx = (cmp_idx_reg == AW'(NUM_SYMBOLS - 1));
    assign last_bit = (bit_cnt_reg == BIT_CNT_W'(BITS_PER_BYTE - 1));
    assign at_limit = (count_reg == CNT_W'(MAX_CODE_LEN));

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_sym_next    = res_sym_reg;
        res_bad_next    = res_bad_reg;
        rq_req          = '0;
        rq_req.symbol   = res_sym_reg;
        rq_req.bad      = res_bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (action == ACT_DECODE))
                begin
                    byte_next    = data_byte;
                    bit_cnt_next = '0;
                    state_next   = ST_BIT;
                end
            end
            ST_BIT:
            begin
                pending_next    = MAX_CODE_LEN'({pending_reg, byte_reg[BITS_PER_BYTE-1]});
                byte_next       = byte_reg << 1;
                count_next      = CNT_W'(count_reg + 1'b1);
                scan_idx_next   = '0;
                issue_done_next = 1'b0;
                cmp_vld_next    = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmp_vld_next = !issue_done_reg;
                cmp_idx_next = scan_idx_reg;
                if (!issue_done_reg)
                begin
                    if (scan_idx_reg == AW'(NUM_SYMBOLS - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (hit)
                begin
                    res_sym_next = SYM_W'(cmp_idx_reg);
                    res_bad_next = 1'b0;
                    state_next   = ST_EMIT;
                end
                else if (cmp_vld_reg && last_idx)
                begin
                    if (at_limit)
                    begin
                        res_sym_next = '0;
                        res_bad_next = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else if (last_bit)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        state_next   = ST_BIT;
                    end
                end
            end
            ST_EMIT:
            begin
                rq_req.push = 1'b1;
                if (rq_st.ready)
                begin
                    pending_next = '0;
                    count_next   = '0;
                    if (last_bit)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        state_next   = ST_BIT;
                    end
                end
            end
            ST_FLUSH:
            begin
                rq_req.flush = 1'b1;
                if (rq_st.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_reg       <= '0;
            bit_cnt_reg    <= '0;
            pending_reg    <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            res_sym_reg    <= '0;
            res_bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_reg       <= byte_next;
            bit_cnt_reg    <= bit_cnt_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            res_sym_reg    <= res_sym_next;
            res_bad_reg    <= res_bad_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CODE_LEN))
        else $error("pending bit count beyond maximum code length");

    a_hit_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit) |=> (state_reg == ST_EMIT && !res_bad_reg))
        else $error("table match not issued as a result");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && rq_st.ready) |=> (count_reg == '0 && pending_reg == '0))
        else $error("pending bits kept after a result");

    a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !rq_st.held)
        else $error("result still held after the byte ended");

endmodule

// File: sv/pcd_table.sv
// Code table memory with per-entry valid bits and a registered read port.
module pcd_table
    import pcd_pkg::*;
#(
    parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
    localparam int AW = $clog2(NUM_SYMBOLS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [LEN_W-1:0]  wr_len,
    input  logic [CODE_W-1:0] wr_code,
    input  logic [AW-1:0]     rd_addr,
    output logic [LEN_W-1:0]  rd_len,
    output logic [CODE_W-1:0] rd_code
);

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    entry_t                  entry_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]  entry_vld_reg;
    entry_t                  rd_entry_reg;
    logic                    rd_vld_reg;
    logic [CODE_W-1:0]       code_mask;

    // drop code bits above the code length
    assign code_mask = ~({CODE_W{1'b1}} << wr_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= entry_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= '{len: wr_len, code: wr_code & code_mask};
        end
        rd_entry_reg <= entry_mem[rd_addr];
    end

    assign rd_len  = rd_vld_reg ? rd_entry_reg.len : '0;
    assign rd_code = rd_entry_reg.code;

endmodule

// File: sv/pcd_result_q.sv
// Result hold slot and output register that marks the last result of a byte.
module pcd_result_q
    import pcd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rq_req_t          req,
    output rq_stat_t         st,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SYM_W-1:0] out_symbol,
    output logic             bad_code,
    output logic             last_of_run
);

    logic             hold_vld_reg, hold_vld_next;
    logic [SYM_W-1:0] hold_sym_reg, hold_sym_next;
    logic             hold_bad_reg, hold_bad_next;
    logic             out_vld_reg, out_vld_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic             out_bad_reg, out_bad_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;

    assign out_free = !out_vld_reg || out_ready;
    assign st.ready = !hold_vld_reg || out_free;
    assign st.held  = hold_vld_reg;

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        hold_sym_next = hold_sym_reg;
        hold_bad_next = hold_bad_reg;
        out_vld_next  = out_vld_reg;
        out_sym_next  = out_sym_reg;
        out_bad_next  = out_bad_reg;
        out_last_next = out_last_reg;

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        // move the held result out once the next one or the byte end shows up
        if ((req.push || req.flush) && st.ready && hold_vld_reg)
        begin
            out_vld_next  = 1'b1;
            out_sym_next  = hold_sym_reg;
            out_bad_next  = hold_bad_reg;
            out_last_next = req.flush;
        end

        if (req.push && st.ready)
        begin
            hold_vld_next = 1'b1;
            hold_sym_next = req.symbol;
            hold_bad_next = req.bad;
        end
        else if (req.flush && st.ready)
        begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            hold_sym_reg <= '0;
            hold_bad_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_sym_reg  <= '0;
            out_bad_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
            hold_sym_reg <= hold_sym_next;
            hold_bad_reg <= hold_bad_next;
            out_vld_reg  <= out_vld_next;
            out_sym_reg  <= out_sym_next;
            out_bad_reg  <= out_bad_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign out_symbol  = out_sym_reg;
    assign bad_code    = out_bad_reg;
    assign last_of_run = out_last_reg;

    a_bad_has_zero_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_bad_reg) |-> (out_sym_reg == '0))
        else $error("error result carries a nonzero symbol");

    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_vld_reg && !req.push && !req.flush) |=> hold_vld_reg)
        else $error("held result dropped without a push or flush");

endmodule
